// ===== design/assert_macros.svh =====
// Assertion macros shared by the PID motor mixer RTL.
// Bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/pidm_pkg.sv =====
// Package for the PID controller with differential motor mix.
// Payload structs, divider request/response and fixed constants; no dependencies.
package pidm_pkg;

    localparam int CMD_W     = 12;
    localparam int GAIN_W    = 24;
    localparam int FRAC_BITS = 16;

    // shared multiplier: signed 33 x signed 25
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 25;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // serial divider: 52-bit magnitude over 32-bit divisor
    localparam int DIV_NUM_W = 52;
    localparam int DIV_DEN_W = 32;

    // APB register map
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam logic [2:0] REG_GAIN_P  = 3'd0;
    localparam logic [2:0] REG_GAIN_I  = 3'd1;
    localparam logic [2:0] REG_GAIN_D  = 3'd2;
    localparam logic [2:0] REG_BASE    = 3'd3;
    localparam logic [2:0] REG_CMD_MIN = 3'd4;
    localparam logic [2:0] REG_CMD_MAX = 3'd5;

    localparam logic [CMD_W-1:0] BASE_RST    = 12'd1300;
    localparam logic [CMD_W-1:0] CMD_MIN_RST = 12'd1000;
    localparam logic [CMD_W-1:0] CMD_MAX_RST = 12'd1400;

    typedef struct packed {
        logic [19:0] measured;
        logic [19:0] target;
        logic [31:0] elapsed;
    } t_pidm_in;

    typedef struct packed {
        logic signed [31:0] drive;
        logic [CMD_W-1:0]   command_plus;
        logic [CMD_W-1:0]   command_minus;
    } t_pidm_out;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 busy;
        logic [DIV_NUM_W-1:0] quot;
        logic                 rem_nz;
    } t_div_rsp;

endpackage

// ===== design/pid_with_differential_motor_mix.sv =====
// PID controller with differential two-motor mix, top level.
// Uses pidm_pkg, pidm_div and assert_macros.svh.
//
// Input channel (i_in_valid / o_in_stall / i_in_data): one transfer carries
// measured, target (Q4.16) and elapsed time (Q8.24). Output channel
// (o_out_valid / i_out_stall / o_out_data): one transfer per input carrying
// the saturated drive (Q16.16) and the two clamped motor commands.
// The user must write gains, base command and clamps over the APB port only
// while idle; the block itself does not enforce this.
// Each item runs through a sequencer around one shared 33x25 multiplier and
// a two-bit-per-cycle serial divider. With nonzero elapsed time the sum waits
// for the divider's 26 steps; with zero elapsed time the divider is skipped.
// o_in_stall is high while an item is in work. A finished result waits in
// the output register; the next item is accepted meanwhile, but its result
// waits in the sequencer until the register is taken.
// Reset (synchronous) clears the integral, the previous sample, the gains
// and loads the default base (1300) and clamps (1000..1400).
`include "assert_macros.svh"
module pid_with_differential_motor_mix
    import pidm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_pidm_in          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_pidm_out         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int ERR_W  = 21;
    localparam int PT_W   = 29;
    localparam int IACC_W = 88;
    localparam int IT_W   = 48;
    localparam int DT_W   = DIV_NUM_W + 1;
    localparam int SUM_W  = 55;
    localparam int CLP_W  = MUL_P_W - FRAC_BITS;
    localparam logic signed [SUM_W-1:0] SUM_MAX = 55'sd2147483647;
    localparam logic signed [SUM_W-1:0] SUM_MIN = -55'sd2147483648;
    localparam logic signed [MUL_A_W-1:0] ONE_Q16 = 33'sd65536;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_P, S_MUL_D, S_MUL_E, S_ACC, S_MUL_ILO, S_MUL_IHI,
        S_ISUM, S_WAIT_DIV, S_SAT, S_MIX_P, S_MIX_M, S_DONE
    } t_state;

    // clamp to max first, then to min
    function automatic logic [CMD_W-1:0] clamp_cmd(
        input logic [MUL_P_W-1:0] prod,
        input logic [CMD_W-1:0]   lo,
        input logic [CMD_W-1:0]   hi
    );
        logic signed [CLP_W-1:0] c;
        c = signed'(prod[MUL_P_W-1:FRAC_BITS]);
        if (c > signed'(CLP_W'(hi))) c = signed'(CLP_W'(hi));
        if (c < signed'(CLP_W'(lo))) c = signed'(CLP_W'(lo));
        return c[CMD_W-1:0];
    endfunction

    // control and state registers
    t_state                    r_state, n_state;
    logic                      r_out_valid, n_out_valid;
    logic signed [GAIN_W-1:0]  r_gain_p, r_gain_i, r_gain_d;
    logic signed [GAIN_W-1:0]  n_gain_p, n_gain_i, n_gain_d;
    logic [CMD_W-1:0]          r_base, r_cmd_min, r_cmd_max;
    logic [CMD_W-1:0]          n_base, n_cmd_min, n_cmd_max;
    logic signed [63:0]        r_integral, n_integral;
    logic [19:0]               r_prev, n_prev;

    // payload registers
    logic signed [ERR_W-1:0]   r_err, n_err;
    logic signed [ERR_W-1:0]   r_diff, n_diff;
    logic [31:0]               r_elap, n_elap;
    logic signed [MUL_P_W-1:0] r_prod, n_prod;
    logic signed [PT_W-1:0]    r_pterm, n_pterm;
    logic                      r_dneg, n_dneg;
    logic signed [IACC_W-1:0]  r_iacc, n_iacc;
    logic signed [SUM_W-1:0]   r_sum, n_sum;
    logic signed [31:0]        r_drive, n_drive;
    logic [CMD_W-1:0]          r_cplus, n_cplus;
    t_pidm_out                 r_out, n_out;

    logic                      in_accept;
    logic                      cfg_wr;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic signed [64:0]        acc_sum;
    logic [43:0]               dmag;
    logic signed [DT_W-1:0]    dterm;
    logic signed [IT_W-1:0]    iterm;
    t_div_req                  div_req;
    t_div_rsp                  div_rsp;

    assign in_accept = i_in_valid && !o_in_stall;
    assign cfg_wr    = psel && penable && pwrite;

    // serial divider for the derivative term
    pidm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MUL_P: begin
                mul_a = MUL_A_W'(r_err);
                mul_b = MUL_B_W'(r_gain_p);
            end
            S_MUL_D: begin
                mul_a = MUL_A_W'(r_diff);
                mul_b = MUL_B_W'(r_gain_d);
            end
            S_MUL_E: begin
                mul_a = signed'({1'b0, r_elap});
                mul_b = MUL_B_W'(r_err);
            end
            S_MUL_ILO: begin
                mul_a = signed'({1'b0, r_integral[31:0]});
                mul_b = MUL_B_W'(r_gain_i);
            end
            S_MUL_IHI: begin
                mul_a = MUL_A_W'(signed'(r_integral[63:32]));
                mul_b = MUL_B_W'(r_gain_i);
            end
            S_MIX_P: begin
                mul_a = ONE_Q16 + MUL_A_W'(r_drive);
                mul_b = signed'(MUL_B_W'(r_base));
            end
            S_MIX_M: begin
                mul_a = ONE_Q16 - MUL_A_W'(r_drive);
                mul_b = signed'(MUL_B_W'(r_base));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // derivative numerator magnitude; the product stays below 2^43
    assign dmag = r_prod[MUL_P_W-1] ? 44'(-r_prod) : 44'(r_prod);

    assign div_req.start = (r_state == S_MUL_E) && (r_elap != '0);
    assign div_req.num   = {dmag, 8'd0};
    assign div_req.den   = r_elap;

    // floored quotient with sign restored
    always_comb begin
        if (r_elap == '0) begin
            dterm = '0;
        end else if (r_dneg) begin
            dterm = -(signed'({1'b0, div_rsp.quot}) + DT_W'(div_rsp.rem_nz));
        end else begin
            dterm = signed'({1'b0, div_rsp.quot});
        end
    end

    assign iterm   = r_iacc[IACC_W-1:40];
    assign acc_sum = 65'(r_integral) + 65'(r_prod);

    // sequencer and datapath next values
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_gain_p    = r_gain_p;
        n_gain_i    = r_gain_i;
        n_gain_d    = r_gain_d;
        n_base      = r_base;
        n_cmd_min   = r_cmd_min;
        n_cmd_max   = r_cmd_max;
        n_integral  = r_integral;
        n_prev      = r_prev;
        n_err       = r_err;
        n_diff      = r_diff;
        n_elap      = r_elap;
        n_prod      = r_prod;
        n_pterm     = r_pterm;
        n_dneg      = r_dneg;
        n_iacc      = r_iacc;
        n_sum       = r_sum;
        n_drive     = r_drive;
        n_cplus     = r_cplus;
        n_out       = r_out;

        // output register drains
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // configuration writes
        if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_GAIN_P:  n_gain_p  = signed'(pwdata[GAIN_W-1:0]);
                REG_GAIN_I:  n_gain_i  = signed'(pwdata[GAIN_W-1:0]);
                REG_GAIN_D:  n_gain_d  = signed'(pwdata[GAIN_W-1:0]);
                REG_BASE:    n_base    = pwdata[CMD_W-1:0];
                REG_CMD_MIN: n_cmd_min = pwdata[CMD_W-1:0];
                REG_CMD_MAX: n_cmd_max = pwdata[CMD_W-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_err   = signed'({1'b0, i_in_data.target})
                            - signed'({1'b0, i_in_data.measured});
                    n_diff  = signed'({1'b0, r_prev})
                            - signed'({1'b0, i_in_data.measured});
                    n_prev  = i_in_data.measured;
                    n_elap  = i_in_data.elapsed;
                    n_state = S_MUL_P;
                end
            end
            S_MUL_P: begin
                n_prod  = mul_p;
                n_state = S_MUL_D;
            end
            S_MUL_D: begin
                n_prod  = mul_p;
                n_pterm = r_prod[PT_W+FRAC_BITS-1:FRAC_BITS];
                n_state = S_MUL_E;
            end
            S_MUL_E: begin
                n_prod  = mul_p;
                n_dneg  = r_prod[MUL_P_W-1];
                n_state = S_ACC;
            end
            S_ACC: begin
                // integral saturates at the 64-bit limits
                if (r_elap != '0) begin
                    if (acc_sum[64] != acc_sum[63]) begin
                        n_integral = acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                    end else begin
                        n_integral = acc_sum[63:0];
                    end
                end
                n_state = S_MUL_ILO;
            end
            S_MUL_ILO: begin
                n_prod  = mul_p;
                n_state = S_MUL_IHI;
            end
            S_MUL_IHI: begin
                n_prod  = mul_p;
                n_iacc  = IACC_W'(r_prod);
                n_state = S_ISUM;
            end
            S_ISUM: begin
                n_iacc  = r_iacc + signed'({r_prod[55:0], 32'd0});
                n_state = S_WAIT_DIV;
            end
            S_WAIT_DIV: begin
                if (!div_rsp.busy) begin
                    n_sum   = SUM_W'(r_pterm) + SUM_W'(iterm) + SUM_W'(dterm);
                    n_state = S_SAT;
                end
            end
            S_SAT: begin
                if (r_sum > SUM_MAX) begin
                    n_drive = SUM_MAX[31:0];
                end else if (r_sum < SUM_MIN) begin
                    n_drive = SUM_MIN[31:0];
                end else begin
                    n_drive = r_sum[31:0];
                end
                n_state = S_MIX_P;
            end
            S_MIX_P: begin
                n_prod  = mul_p;
                n_state = S_MIX_M;
            end
            S_MIX_M: begin
                n_prod  = mul_p;
                n_cplus = clamp_cmd(r_prod, r_cmd_min, r_cmd_max);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.drive         = r_drive;
                    n_out.command_plus  = r_cplus;
                    n_out.command_minus = clamp_cmd(r_prod, r_cmd_min, r_cmd_max);
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state, configuration and registered outputs
    always_ff @(posedge i_clk) begin
        r_err   <= n_err;
        r_diff  <= n_diff;
        r_elap  <= n_elap;
        r_prod  <= n_prod;
        r_pterm <= n_pterm;
        r_dneg  <= n_dneg;
        r_iacc  <= n_iacc;
        r_sum   <= n_sum;
        r_drive <= n_drive;
        r_cplus <= n_cplus;
        r_out   <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_base      <= BASE_RST;
            r_cmd_min   <= CMD_MIN_RST;
            r_cmd_max   <= CMD_MAX_RST;
            r_integral  <= '0;
            r_prev      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_gain_p    <= n_gain_p;
            r_gain_i    <= n_gain_i;
            r_gain_d    <= n_gain_d;
            r_base      <= n_base;
            r_cmd_min   <= n_cmd_min;
            r_cmd_max   <= n_cmd_max;
            r_integral  <= n_integral;
            r_prev      <= n_prev;
        end
    end

    // register read-back
    always_comb begin
        unique case (paddr[4:2])
            REG_GAIN_P:  prdata = DATA_W'(unsigned'(r_gain_p));
            REG_GAIN_I:  prdata = DATA_W'(unsigned'(r_gain_i));
            REG_GAIN_D:  prdata = DATA_W'(unsigned'(r_gain_d));
            REG_BASE:    prdata = DATA_W'(r_base);
            REG_CMD_MIN: prdata = DATA_W'(r_cmd_min);
            REG_CMD_MAX: prdata = DATA_W'(r_cmd_max);
            default:     prdata = '0;
        endcase
    end

    assign pready      = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    `ASSERT_IMPLY(a_div_busy_not_idle, i_clk, i_rst_n, div_rsp.busy, r_state != S_IDLE, "divider running while sequencer idle")
    `ASSERT_NEXT(a_accept_stalls, i_clk, i_rst_n, in_accept, o_in_stall, "input not stalled after a transfer")
    `ASSERT_NEXT(a_zero_dt_integral, i_clk, i_rst_n, (r_state == S_ACC) && (r_elap == '0), $stable(r_integral), "integral moved with zero elapsed time")

endmodule

// ===== design/pidm_div.sv =====
// Unsigned restoring divider, two quotient bits per cycle.
// Depends on pidm_pkg for widths and the request/response structs.
module pidm_div
    import pidm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int STEPS = DIV_NUM_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_DEN_W:0]   r_rem;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_den;

    logic [DIV_DEN_W:0]   n_rem;
    logic [DIV_NUM_W-1:0] n_quo;
    logic [DIV_DEN_W:0]   shifted;

    // two compare-subtract steps; remainder stays below the divisor
    always_comb begin
        n_rem   = r_rem;
        n_quo   = r_quo;
        shifted = '0;
        for (int k = 0; k < 2; k++) begin
            shifted = {n_rem[DIV_DEN_W-1:0], n_quo[DIV_NUM_W-1]};
            n_quo   = {n_quo[DIV_NUM_W-2:0], 1'b0};
            if (shifted >= {1'b0, r_den}) begin
                n_rem    = shifted - {1'b0, r_den};
                n_quo[0] = 1'b1;
            end else begin
                n_rem = shifted;
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.busy   = r_busy;
    assign o_rsp.quot   = r_quo;
    assign o_rsp.rem_nz = |r_rem;

endmodule
